// ===== design/esp_pkg.sv =====
// types, codes and fixed constants shared by the encoder speed/position loop
// no dependencies
`default_nettype none

package esp_pkg;

   localparam int FUNC_WIDTH      = 2;
   localparam int GAIN_WIDTH      = 16;
   localparam int GAIN_FRAC       = 8;
   localparam int SPEED_WIDTH     = 28;
   localparam int DRIVE_WIDTH     = 16;
   localparam int COEF_WIDTH      = 17;
   localparam int COEF_SHIFT      = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   // 0.8 and 0.32 in Q0.16
   localparam logic signed [COEF_WIDTH-1:0] KEEP_COEF = 17'sd52429;
   localparam logic signed [COEF_WIDTH-1:0] FEED_COEF = 17'sd20972;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_LEFT  = 2'd0,
      FUNC_RIGHT = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INTEGRAL_GAIN     = 1'b0,
      CSR_PROPORTIONAL_GAIN = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILTER_MUL,
      ST_FILTER_SUM,
      ST_POSITION,
      ST_DRIVE_MUL,
      ST_DRIVE_SUM
   } state_type;

   typedef struct packed {
      logic count_left;
      logic count_right;
      logic latch_sum;
      logic filter_mul;
      logic filter_sum;
      logic position;
      logic drive_mul;
      logic drive_load;
   } cmd_type;

   typedef struct packed {
      logic rsp_stall;
   } status_type;

endpackage

`default_nettype wire

// ===== design/esp_req_if.sv =====
// request channel: encoder pulse events and control ticks
// depends on esp_pkg
`default_nettype none

interface esp_req_if;
   logic                           valid;
   logic                           ready;
   logic [esp_pkg::FUNC_WIDTH-1:0] func;
   logic                           direction;

   modport source (output valid, func, direction, input ready);
   modport sink   (input valid, func, direction, output ready);
endinterface

`default_nettype wire

// ===== design/esp_rsp_if.sv =====
// response channel: drive value per control tick
// depends on esp_pkg
`default_nettype none

interface esp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [esp_pkg::DRIVE_WIDTH-1:0] drive_value;

   modport source (output valid, drive_value, input ready);
   modport sink   (input valid, drive_value, output ready);
endinterface

`default_nettype wire

// ===== design/esp_ctrl.sv =====
// sequencer for pulse counting and the tick computation steps
// depends on esp_pkg
`default_nettype none

module esp_ctrl (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire [esp_pkg::FUNC_WIDTH-1:0]     req_func,
   output logic                              req_ready,
   input  esp_pkg::status_type               status,
   output esp_pkg::cmd_type                  cmd
);

   esp_pkg::state_type state_ff, state_in;
   logic               accept;

   assign req_ready = (state_ff == esp_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         esp_pkg::ST_IDLE: begin
            if (accept && req_func == esp_pkg::FUNC_TICK) begin
               state_in = esp_pkg::ST_FILTER_MUL;
            end
         end
         esp_pkg::ST_FILTER_MUL: state_in = esp_pkg::ST_FILTER_SUM;
         esp_pkg::ST_FILTER_SUM: state_in = esp_pkg::ST_POSITION;
         esp_pkg::ST_POSITION:   state_in = esp_pkg::ST_DRIVE_MUL;
         esp_pkg::ST_DRIVE_MUL:  state_in = esp_pkg::ST_DRIVE_SUM;
         esp_pkg::ST_DRIVE_SUM: begin
            if (!status.rsp_stall) begin
               state_in = esp_pkg::ST_IDLE;
            end
         end
         default: state_in = esp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         esp_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  esp_pkg::FUNC_LEFT:  cmd.count_left  = 1'b1;
                  esp_pkg::FUNC_RIGHT: cmd.count_right = 1'b1;
                  esp_pkg::FUNC_TICK:  cmd.latch_sum   = 1'b1;
                  default:             cmd = '0;
               endcase
            end
         end
         esp_pkg::ST_FILTER_MUL: cmd.filter_mul = 1'b1;
         esp_pkg::ST_FILTER_SUM: cmd.filter_sum = 1'b1;
         esp_pkg::ST_POSITION:   cmd.position   = 1'b1;
         esp_pkg::ST_DRIVE_MUL:  cmd.drive_mul  = 1'b1;
         esp_pkg::ST_DRIVE_SUM:  cmd.drive_load = !status.rsp_stall;
         default:                cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/esp_datapath.sv =====
// counters, speed filter, position integrator, drive computation and gains
// depends on esp_pkg
`default_nettype none

module esp_datapath #(
   parameter int COUNT_WIDTH    = 16,
   parameter int POSITION_LIMIT = 3500,
   parameter int FRAC_BITS      = 8
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  esp_pkg::cmd_type                            cmd,
   output esp_pkg::status_type                         status,
   input  wire                                         req_direction,
   input  wire                                         csr_write,
   input  wire [esp_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  wire [esp_pkg::GAIN_WIDTH-1:0]               csr_wdata,
   output logic                                        rsp_valid,
   input  wire                                         rsp_ready,
   output logic signed [esp_pkg::DRIVE_WIDTH-1:0]      rsp_drive_value
);

   localparam int SW    = esp_pkg::SPEED_WIDTH;
   localparam int GW    = esp_pkg::GAIN_WIDTH;
   localparam int KW    = esp_pkg::COEF_WIDTH;
   localparam int OW    = esp_pkg::DRIVE_WIDTH;
   localparam int CW    = COUNT_WIDTH;
   localparam int SUMW  = CW + 1;
   localparam int PA_W  = SW + KW;
   localparam int PB_W  = SUMW + KW;
   localparam int FA_W  = ((PA_W > PB_W + FRAC_BITS) ? PA_W : PB_W + FRAC_BITS) + 1;
   localparam longint POS_LIM_Q = longint'(POSITION_LIMIT) << FRAC_BITS;
   localparam int PW    = $clog2(POS_LIM_Q + 1) + 1;
   localparam int QW    = ((PW > SW) ? PW : SW) + 1;
   localparam int IW    = GW + PW;
   localparam int JW    = GW + SW;
   localparam int DW    = ((IW > JW) ? IW : JW) + 1;
   localparam int DS    = esp_pkg::GAIN_FRAC + FRAC_BITS;

   localparam logic signed [CW-1:0]   CNT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0]   CNT_MIN = ~CNT_MAX;
   localparam logic signed [FA_W-1:0] SPD_MAX = FA_W'({1'b0, {(SW-1){1'b1}}});
   localparam logic signed [FA_W-1:0] SPD_MIN = ~SPD_MAX;
   localparam logic signed [QW-1:0]   POS_MAX = QW'(POS_LIM_Q);
   localparam logic signed [QW-1:0]   POS_MIN = -POS_MAX;
   localparam logic signed [DW-1:0]   RND     = DW'((longint'(1) << DS) - 1);
   localparam logic signed [DW-1:0]   DRV_MAX = DW'({1'b0, {(OW-1){1'b1}}});
   localparam logic signed [DW-1:0]   DRV_MIN = ~DRV_MAX;

   logic signed [GW-1:0]   igain_ff, pgain_ff;
   logic signed [CW-1:0]   left_cnt_ff, left_cnt_in, right_cnt_ff, right_cnt_in;
   logic signed [SUMW-1:0] sum_ff;
   logic signed [PA_W-1:0] prod_a_ff;
   logic signed [PB_W-1:0] prod_b_ff;
   logic signed [SW-1:0]   speed_ff, speed_in;
   logic signed [PW-1:0]   pos_ff, pos_in;
   logic signed [IW-1:0]   prod_i_ff;
   logic signed [JW-1:0]   prod_p_ff;
   logic signed [OW-1:0]   drive_ff, drive_in;
   logic                   rsp_valid_ff;

   logic signed [FA_W-1:0] filt_acc, filt_shift;
   logic signed [QW-1:0]   pos_sum;
   logic signed [DW-1:0]   drv_acc, drv_biased, drv_shift;

   assign status.rsp_stall = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_value  = drive_ff;

   // gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         igain_ff <= '0;
         pgain_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            esp_pkg::CSR_INTEGRAL_GAIN:     igain_ff <= csr_wdata;
            esp_pkg::CSR_PROPORTIONAL_GAIN: pgain_ff <= csr_wdata;
            default: begin
               igain_ff <= igain_ff;
            end
         endcase
      end
   end

   // saturating pulse counters
   always_comb begin
      left_cnt_in  = left_cnt_ff;
      right_cnt_in = right_cnt_ff;
      if (cmd.latch_sum) begin
         left_cnt_in  = '0;
         right_cnt_in = '0;
      end
      if (cmd.count_left) begin
         if (req_direction && left_cnt_ff != CNT_MAX) begin
            left_cnt_in = left_cnt_ff + CW'(1);
         end else if (!req_direction && left_cnt_ff != CNT_MIN) begin
            left_cnt_in = left_cnt_ff - CW'(1);
         end
      end
      if (cmd.count_right) begin
         if (req_direction && right_cnt_ff != CNT_MAX) begin
            right_cnt_in = right_cnt_ff + CW'(1);
         end else if (!req_direction && right_cnt_ff != CNT_MIN) begin
            right_cnt_in = right_cnt_ff - CW'(1);
         end
      end
   end

   // speed filter
   always_comb begin
      filt_acc   = FA_W'(prod_a_ff) + (FA_W'(prod_b_ff) <<< FRAC_BITS);
      filt_shift = filt_acc >>> esp_pkg::COEF_SHIFT;
      if (filt_shift > SPD_MAX) begin
         speed_in = SW'(SPD_MAX);
      end else if (filt_shift < SPD_MIN) begin
         speed_in = SW'(SPD_MIN);
      end else begin
         speed_in = filt_shift[SW-1:0];
      end
   end

   // position integrator
   always_comb begin
      pos_sum = QW'(pos_ff) + QW'(speed_ff);
      if (pos_sum > POS_MAX) begin
         pos_in = PW'(POS_MAX);
      end else if (pos_sum < POS_MIN) begin
         pos_in = PW'(POS_MIN);
      end else begin
         pos_in = pos_sum[PW-1:0];
      end
   end

   // drive: truncate toward zero, then saturate
   always_comb begin
      drv_acc    = DW'(prod_i_ff) + DW'(prod_p_ff);
      drv_biased = drv_acc[DW-1] ? drv_acc + RND : drv_acc;
      drv_shift  = drv_biased >>> DS;
      if (drv_shift > DRV_MAX) begin
         drive_in = OW'(DRV_MAX);
      end else if (drv_shift < DRV_MIN) begin
         drive_in = OW'(DRV_MIN);
      end else begin
         drive_in = drv_shift[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_cnt_ff  <= '0;
         right_cnt_ff <= '0;
         speed_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_cnt_ff  <= left_cnt_in;
         right_cnt_ff <= right_cnt_in;
         if (cmd.filter_sum) begin
            speed_ff <= speed_in;
         end
         if (cmd.position) begin
            pos_ff <= pos_in;
         end
         if (cmd.drive_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_sum) begin
         sum_ff <= SUMW'(left_cnt_ff) + SUMW'(right_cnt_ff);
      end
      if (cmd.filter_mul) begin
         prod_a_ff <= PA_W'(speed_ff) * PA_W'(esp_pkg::KEEP_COEF);
         prod_b_ff <= PB_W'(sum_ff) * PB_W'(esp_pkg::FEED_COEF);
      end
      if (cmd.drive_mul) begin
         prod_i_ff <= IW'(igain_ff) * IW'(pos_ff);
         prod_p_ff <= JW'(pgain_ff) * JW'(speed_ff);
      end
      if (cmd.drive_load) begin
         drive_ff <= drive_in;
      end
   end

   a_counters_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_sum |=> (left_cnt_ff == '0 && right_cnt_ff == '0))
      else $error("counters not cleared after tick");

   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      (QW'(pos_ff) <= POS_MAX) && (QW'(pos_ff) >= POS_MIN))
      else $error("position outside limit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.drive_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending drive value overwritten");

endmodule

`default_nettype wire

// ===== design/encoder_speed_position_loop.sv =====
// top level: encoder pulse counting with filtered speed and position drive loop
// a pulse updates its counter; a tick runs filter mul, filter sum, position, drive mul and drive
// sum states, then its drive value is registered; throughput: one pulse per cycle while idle;
// ready stays low through a tick, as its steps share one sequencer, and through any output stall
// reset: synchronous; counters, speed, position and gains clear to zero
// depends on esp_pkg, esp_req_if, esp_rsp_if, esp_ctrl, esp_datapath
`default_nettype none

module encoder_speed_position_loop #(
   parameter int COUNT_WIDTH    = 16,
   parameter int POSITION_LIMIT = 3500,
   parameter int FRAC_BITS      = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   esp_req_if.sink                             req_chan,
   esp_rsp_if.source                           rsp_chan,
   input  wire                                 csr_write,
   input  wire [esp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [esp_pkg::GAIN_WIDTH-1:0]       csr_wdata
);

   esp_pkg::cmd_type    cmd;
   esp_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;
   logic signed [esp_pkg::DRIVE_WIDTH-1:0] rsp_drive_value;

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.drive_value = rsp_drive_value;

   esp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   esp_datapath #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .POSITION_LIMIT (POSITION_LIMIT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_direction   (req_chan.direction),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_drive_value (rsp_drive_value)
   );

endmodule

`default_nettype wire
